// ===== rtl/core/vbdq_pkg.sv =====
// Shared types, result codes and helpers for the video backlog drop queue.
package vbdq_pkg;

  // Request codes
  localparam logic [2:0] REQ_PUSH   = 3'd0;
  localparam logic [2:0] REQ_DEQ    = 3'd1;
  localparam logic [2:0] REQ_SENT   = 3'd2;
  localparam logic [2:0] REQ_RESYNC = 3'd3;
  localparam logic [2:0] REQ_STATS  = 3'd4;

  // Result codes
  localparam logic [3:0] RES_QUEUED  = 4'd0;
  localparam logic [3:0] RES_DROPPED = 4'd1;
  localparam logic [3:0] RES_IGNORED = 4'd2;
  localparam logic [3:0] RES_DEQ     = 4'd3;
  localparam logic [3:0] RES_EMPTY   = 4'd4;
  localparam logic [3:0] RES_SENT    = 4'd5;
  localparam logic [3:0] RES_DEAD    = 4'd6;
  localparam logic [3:0] RES_RESYNC  = 4'd7;
  localparam logic [3:0] RES_STAT    = 4'd8;
  localparam logic [3:0] RES_FULL    = 4'd9;

  // Statistic indexes
  localparam logic [2:0] STAT_PKTS       = 3'd0;
  localparam logic [2:0] STAT_BYTES      = 3'd1;
  localparam logic [2:0] STAT_DROP_PKTS  = 3'd2;
  localparam logic [2:0] STAT_DROP_BYTES = 3'd3;
  localparam logic [2:0] STAT_FLUSHES    = 3'd4;
  localparam logic [2:0] STAT_PEAK       = 3'd5;
  localparam logic [2:0] STAT_QUEUED     = 3'd6;
  localparam int         NumCounters     = 6;

  // Per-cell control: shift from neighbor, or load from the controller
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // Saturating 48-bit add
  function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? {48{1'b1}} : s[47:0];
  endfunction

endpackage

// ===== rtl/core/vbdq_cell.sv =====
// One descriptor cell of the queue chain: loads a new entry or takes its neighbor's.
module vbdq_cell
  import vbdq_pkg::*;
#(
  parameter int TAG_BITS = 16
) (
  input  logic                clk_i,
  input  cell_ctrl_t          ctrl_i,
  input  logic [TAG_BITS-1:0] ld_tag_i,
  input  logic [23:0]         ld_len_i,
  input  logic                ld_vid_i,
  input  logic [TAG_BITS-1:0] nb_tag_i,
  input  logic [23:0]         nb_len_i,
  input  logic                nb_vid_i,
  output logic [TAG_BITS-1:0] tag_o,
  output logic [23:0]         len_o,
  output logic                vid_o
);

  logic [TAG_BITS-1:0] tag_q;
  logic [23:0]         len_q;
  logic                vid_q;

  // Load wins over shift
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      tag_q <= ld_tag_i;
      len_q <= ld_len_i;
      vid_q <= ld_vid_i;
    end else if (ctrl_i.shift) begin
      tag_q <= nb_tag_i;
      len_q <= nb_len_i;
      vid_q <= nb_vid_i;
    end
  end

  assign tag_o = tag_q;
  assign len_o = len_q;
  assign vid_o = vid_q;

endmodule

// ===== rtl/core/video_backlog_drop_queue_unit.sv =====
// Top level: byte-budget descriptor queue with selective video flush.
//
// Requests enter on the in channel (in_valid_i / in_stall_o) and results leave
// on the out channel (out_valid_o / out_stall_i); a beat moves when valid is
// high and stall is low. The byte budget is written on the cfg channel
// (cfg_valid_i / cfg_ready_o); ready is always high.
// Dequeue, send done and resync give one result, registered in the cycle after
// the beat. A push passes through the settle state before its result is
// registered; a push that triggers a backlog flush first passes through the
// flush state, which walks the chain of cells from the head over every queued
// entry, rotating kept entries to the tail and dropping video ones. Take stats
// gives seven result beats from the stats state, one per cycle while accepted.
// Requests are taken one at a time; a new one is accepted once the controller
// is idle and the output register is empty or being drained.
// When the receiver stalls, the result is held in the output register and
// further requests wait. Reset empties the queue, clears all counters and
// flags, and sets the budget to 8388608 bytes; no clearing pass is needed.
module video_backlog_drop_queue_unit
  import vbdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int TAG_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [23:0] packet_bytes_i,
  input  logic        is_video_i,
  input  logic        is_keyframe_i,
  input  logic [15:0] packet_tag_i,
  input  logic        send_ok_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  result_kind_o,
  output logic [15:0] out_tag_o,
  output logic [23:0] out_bytes_o,
  output logic [6:0]  flushed_entries_o,
  output logic        resync_flag_o,
  output logic [2:0]  stat_id_o,
  output logic [47:0] stat_value_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;
  localparam logic [1:0] ST_STATS = 2'd3;

  // Control state
  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] left_q, left_d;
  logic [CW-1:0] nflush_q, nflush_d;
  logic [30:0]   total_q, total_d;
  logic          resync_q, resync_d;
  logic          dead_q, dead_d;
  logic          pflush_q, pflush_d;
  logic [2:0]    sidx_q, sidx_d;
  logic [31:0]   budget_q;
  logic [47:0]   stat_q [NumCounters];
  logic [47:0]   stat_d [NumCounters];

  // Held push
  logic [23:0]         plen_q;
  logic                pvid_q, pkey_q;
  logic [TAG_BITS-1:0] ptag_q;

  // Output register
  logic        ov_q, ov_d;
  logic [3:0]  okind_q, okind_d;
  logic [15:0] otag_q, otag_d;
  logic [23:0] obytes_q, obytes_d;
  logic [6:0]  ofl_q, ofl_d;
  logic        orf_q, orf_d;
  logic [2:0]  osid_q, osid_d;
  logic [47:0] osval_q, osval_d;
  logic        olast_q, olast_d;

  // Chain signals
  cell_ctrl_t          ctrl [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] c_tag [QUEUE_DEPTH];
  logic [23:0]         c_len [QUEUE_DEPTH];
  logic                c_vid [QUEUE_DEPTH];
  logic                shift;
  logic                ld_en;
  logic [IW-1:0]       ld_idx;
  logic [TAG_BITS-1:0] ld_tag;
  logic [23:0]         ld_len;
  logic                ld_vid;

  logic        out_free, in_acc;
  logic [31:0] want;
  logic [31:0] tag_ext;

  assign out_free    = !ov_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ST_IDLE) && out_free);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign want        = {1'b0, total_q} + {8'd0, packet_bytes_i};
  assign tag_ext     = {16'd0, packet_tag_i};

  // Build the row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [TAG_BITS-1:0] nb_tag;
    logic [23:0]         nb_len;
    logic                nb_vid;
    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign nb_tag = '0;
      assign nb_len = '0;
      assign nb_vid = 1'b0;
    end else begin : g_mid
      assign nb_tag = c_tag[i+1];
      assign nb_len = c_len[i+1];
      assign nb_vid = c_vid[i+1];
    end
    assign ctrl[i].shift = shift;
    assign ctrl[i].load  = ld_en && (ld_idx == IW'(i));
    vbdq_cell #(.TAG_BITS(TAG_BITS)) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl[i]),
      .ld_tag_i (ld_tag),
      .ld_len_i (ld_len),
      .ld_vid_i (ld_vid),
      .nb_tag_i (nb_tag),
      .nb_len_i (nb_len),
      .nb_vid_i (nb_vid),
      .tag_o    (c_tag[i]),
      .len_o    (c_len[i]),
      .vid_o    (c_vid[i])
    );
  end

  // Sequencer and request handling
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    left_d   = left_q;
    nflush_d = nflush_q;
    total_d  = total_q;
    resync_d = resync_q;
    dead_d   = dead_q;
    pflush_d = pflush_q;
    sidx_d   = sidx_q;
    for (int k = 0; k < NumCounters; k++) stat_d[k] = stat_q[k];
    shift  = 1'b0;
    ld_en  = 1'b0;
    ld_idx = count_q[IW-1:0];
    ld_tag = ptag_q;
    ld_len = plen_q;
    ld_vid = pvid_q;
    ov_d     = ov_q && out_stall_i;
    okind_d  = okind_q;
    otag_d   = otag_q;
    obytes_d = obytes_q;
    ofl_d    = ofl_q;
    orf_d    = orf_q;
    osid_d   = osid_q;
    osval_d  = osval_q;
    olast_d  = olast_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // default result fields
          otag_d   = '0;
          obytes_d = '0;
          ofl_d    = '0;
          orf_d    = 1'b0;
          osid_d   = '0;
          osval_d  = '0;
          olast_d  = 1'b1;
          unique case (req_type_i)
            REQ_PUSH: begin
              if (dead_q) begin
                ov_d    = 1'b1;
                okind_d = RES_IGNORED;
              end else begin
                if ({16'd0, want} > stat_q[STAT_PEAK]) stat_d[STAT_PEAK] = {16'd0, want};
                nflush_d = '0;
                if (is_video_i && (want > budget_q)) begin
                  stat_d[STAT_FLUSHES] = sat48(stat_q[STAT_FLUSHES], 48'd1);
                  pflush_d = 1'b1;
                  left_d   = count_q;
                  state_d  = ST_FLUSH;
                end else begin
                  pflush_d = 1'b0;
                  state_d  = ST_FIN;
                end
              end
            end
            REQ_DEQ: begin
              ov_d = 1'b1;
              if (count_q == '0) begin
                okind_d = RES_EMPTY;
              end else begin
                okind_d  = RES_DEQ;
                otag_d   = 16'(c_tag[0]);
                obytes_d = c_len[0];
                shift    = 1'b1;
                count_d  = count_q - CW'(1);
                total_d  = total_q - {7'd0, c_len[0]};
              end
            end
            REQ_SENT: begin
              ov_d    = 1'b1;
              okind_d = RES_DEAD;
              if (!dead_q) begin
                if (!send_ok_i) begin
                  dead_d  = 1'b1;
                  count_d = '0;
                  total_d = '0;
                end else begin
                  okind_d = RES_SENT;
                  stat_d[STAT_PKTS]  = sat48(stat_q[STAT_PKTS], 48'd1);
                  stat_d[STAT_BYTES] = sat48(stat_q[STAT_BYTES], {24'd0, packet_bytes_i});
                end
              end
            end
            REQ_RESYNC: begin
              ov_d     = 1'b1;
              okind_d  = RES_RESYNC;
              orf_d    = resync_q;
              resync_d = 1'b0;
            end
            REQ_STATS: begin
              sidx_d  = STAT_PKTS;
              state_d = ST_STATS;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FLUSH: begin
        // Walk the head: drop video, rotate the rest to the tail
        if (left_q == '0) begin
          state_d = ST_FIN;
        end else begin
          left_d = left_q - CW'(1);
          shift  = 1'b1;
          if (c_vid[0]) begin
            count_d  = count_q - CW'(1);
            total_d  = total_q - {7'd0, c_len[0]};
            nflush_d = nflush_q + CW'(1);
            stat_d[STAT_DROP_PKTS]  = sat48(stat_q[STAT_DROP_PKTS], 48'd1);
            stat_d[STAT_DROP_BYTES] = sat48(stat_q[STAT_DROP_BYTES], {24'd0, c_len[0]});
          end else begin
            ld_en  = 1'b1;
            ld_idx = IW'(count_q - CW'(1));
            ld_tag = c_tag[0];
            ld_len = c_len[0];
            ld_vid = c_vid[0];
          end
        end
      end
      ST_FIN: begin
        // Settle the held push
        ov_d    = 1'b1;
        ofl_d   = 7'(nflush_q);
        state_d = ST_IDLE;
        if ((pflush_q && !pkey_q) || (count_q >= DepthC)) begin
          okind_d = (pflush_q && !pkey_q) ? RES_DROPPED : RES_FULL;
          if (pflush_q && !pkey_q) resync_d = 1'b1;
          stat_d[STAT_DROP_PKTS]  = sat48(stat_q[STAT_DROP_PKTS], 48'd1);
          stat_d[STAT_DROP_BYTES] = sat48(stat_q[STAT_DROP_BYTES], {24'd0, plen_q});
        end else begin
          okind_d = RES_QUEUED;
          ld_en   = 1'b1;
          count_d = count_q + CW'(1);
          total_d = total_q + {7'd0, plen_q};
        end
      end
      ST_STATS: begin
        // Issue one statistic per free output slot
        if (out_free) begin
          ov_d     = 1'b1;
          okind_d  = RES_STAT;
          osid_d   = sidx_q;
          otag_d   = '0;
          obytes_d = '0;
          ofl_d    = '0;
          orf_d    = 1'b0;
          if (sidx_q == STAT_QUEUED) begin
            osval_d = {17'd0, total_q};
            olast_d = 1'b1;
            for (int k = 0; k < NumCounters; k++) stat_d[k] = '0;
            state_d = ST_IDLE;
          end else begin
            osval_d = stat_q[sidx_q];
            olast_d = 1'b0;
            sidx_d  = sidx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      left_q   <= '0;
      nflush_q <= '0;
      total_q  <= '0;
      resync_q <= 1'b0;
      dead_q   <= 1'b0;
      pflush_q <= 1'b0;
      sidx_q   <= '0;
      ov_q     <= 1'b0;
      budget_q <= 32'd8388608;
      for (int k = 0; k < NumCounters; k++) stat_q[k] <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      left_q   <= left_d;
      nflush_q <= nflush_d;
      total_q  <= total_d;
      resync_q <= resync_d;
      dead_q   <= dead_d;
      pflush_q <= pflush_d;
      sidx_q   <= sidx_d;
      ov_q     <= ov_d;
      if (cfg_valid_i) budget_q <= cfg_data_i;
      for (int k = 0; k < NumCounters; k++) stat_q[k] <= stat_d[k];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    okind_q  <= okind_d;
    otag_q   <= otag_d;
    obytes_q <= obytes_d;
    ofl_q    <= ofl_d;
    orf_q    <= orf_d;
    osid_q   <= osid_d;
    osval_q  <= osval_d;
    olast_q  <= olast_d;
    if (in_acc) begin
      plen_q <= packet_bytes_i;
      pvid_q <= is_video_i;
      pkey_q <= is_keyframe_i;
      ptag_q <= TAG_BITS'(tag_ext);
    end
  end

  assign out_valid_o       = ov_q;
  assign result_kind_o     = okind_q;
  assign out_tag_o         = otag_q;
  assign out_bytes_o       = obytes_q;
  assign flushed_entries_o = ofl_q;
  assign resync_flag_o     = orf_q;
  assign stat_id_o         = osid_q;
  assign stat_value_o      = osval_q;
  assign last_o            = olast_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC) else $error("entry count above depth");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> (left_q <= count_q)) else $error("flush walk past count");
  a_flush_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> !ov_q) else $error("result pending during flush");
  a_dead_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dead_q |-> (count_q == '0)) else $error("dead link with queued entries");
`endif

endmodule
